@@ design/mlq_pkg.sv @@
// Shared types and constants of the multilevel queue CPU scheduler.
package mlq_pkg;

   localparam int LEVELS         = 5;
   localparam int RUNS_PER_AGING = 10;
   localparam int REPORT_LIMIT   = 8;

   localparam logic [2:0]  TOP_LEVEL  = 3'd4;
   localparam logic [16:0] UNLAUNCHED = 17'h10000;

   // Request function codes
   localparam logic FUNC_ADMIT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Result kinds
   localparam logic KIND_ADMIT = 1'b0;
   localparam logic KIND_SLOT  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_CPU_COUNT = 1'b0;
   localparam logic CSR_MEM_CAP   = 1'b1;

   // One process table word
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] remaining;
      logic [15:0] planned;
      logic [16:0] launch;
      logic [3:0]  run_count;
      logic [15:0] memory;
      logic [2:0]  level;
      logic [2:0]  base_level;
      logic [15:0] observed;
   } proc_entry_type;

   // One buffered CPU slot report
   typedef struct packed {
      logic        disp;
      logic        fin;
      logic [5:0]  pid;
      logic [15:0] arrival;
      logic [15:0] launch;
      logic [15:0] planned;
      logic [15:0] observed;
   } report_type;

endpackage

@@ design/multilevel_queue_cpu_scheduler_core.sv @@
// Top level of the multilevel queue CPU scheduler.
//
// Requests (req_*) are admits or ticks; results (rsp_*) leave through an output
// register; configuration writes arrive on csr_* and are always ready.
// An admit's result enters the output register from S_ADMIT once it is free.
// A tick walks the stored state with registered-read memories: it ages every
// queued process, releases due pending processes and examines queue heads
// for each CPU slot (dispatch), then buffers its slot reports and delivers
// one per cycle while the output is not stalled, the last one flagged.
// One request is worked on at a time: req_stall is high from the transfer
// until the last result of the request has entered the output register.
// A stalled result holds in the output register; the block waits for it.
// Reset (synchronous, active high) empties queues and the pending list,
// frees every table slot, and sets cpu_count to 1 and memory_capacity to
// 65535; no memory clearing pass is needed.
module multilevel_queue_cpu_scheduler_core #(
   parameter int MAX_PROCESSES = 64,
   parameter int MAX_CPUS      = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_slice_count,
   input  logic [15:0] req_memory_need,
   input  logic [2:0]  req_start_priority,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_cpu_slot,
   output logic        rsp_dispatched,
   output logic [5:0]  rsp_process_id,
   output logic        rsp_finished,
   output logic [15:0] rsp_arrival_out,
   output logic [15:0] rsp_launch_time,
   output logic [15:0] rsp_planned_duration,
   output logic [15:0] rsp_observed_duration,
   output logic        rsp_system_idle,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import mlq_pkg::*;

   localparam int PW = $clog2(MAX_PROCESSES);
   localparam int CW = PW + 1;
   localparam int NB = (MAX_CPUS < REPORT_LIMIT) ? MAX_CPUS : REPORT_LIMIT;
   localparam int SW = (NB > 1) ? $clog2(NB) : 1;
   localparam logic [3:0]    NB_W  = 4'(NB);
   localparam logic [CW-1:0] MAXP_C = CW'(MAX_PROCESSES);
   localparam logic [2:0]    LEVELS_C = 3'(LEVELS);

   typedef enum logic [3:0] {
      S_IDLE, S_ADMIT,
      S_AGE_Q, S_AGE_T, S_AGE_W,
      S_REL_Q, S_REL_T, S_REL_W,
      S_DSP_L, S_DSP_Q, S_DSP_T, S_DSP_D,
      S_FIN, S_OUT
   } state_type;

   // Add two positions and fold into the queue ring
   function automatic logic [PW-1:0] wrap(logic [CW-1:0] a, logic [CW-1:0] b);
      logic [CW-1:0] s;
      s = a + b;
      if (s >= MAXP_C) s = s - MAXP_C;
      return s[PW-1:0];
   endfunction

   // Level change applied every tenth run
   function automatic logic [2:0] aged_level(logic [2:0] lv, logic [2:0] b);
      logic [2:0] r;
      r = lv;
      if (b != 3'd0 && b != TOP_LEVEL) begin
         if (lv != TOP_LEVEL || b == lv) r = lv + 3'd1;
         else r = lv - 3'd1;
         if (r > TOP_LEVEL) r = TOP_LEVEL;
      end
      return r;
   endfunction

   state_type state_ff;

   logic [3:0]  cpu_count_ff;
   logic [15:0] mem_cap_ff;
   logic [MAX_PROCESSES-1:0] free_ff;
   logic [MAX_PROCESSES-1:0] ran_ff;
   logic [PW-1:0] head_ff [LEVELS];
   logic [CW-1:0] count_ff [LEVELS];
   logic [CW-1:0] pend_cnt_ff;
   logic [15:0] tick_ff;
   logic [16:0] mem_use_ff;
   logic [2:0]  lvl_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] keep_ff;
   logic [CW-1:0] n_ff;
   logic [3:0]  slot_ff;
   logic [3:0]  ncpu_ff;
   logic        idle_ff;
   report_type  rpt_ff [NB];

   // Latched admit request
   logic [15:0] arr_ff, slice_ff, need_ff;
   logic [2:0]  prio_ff;

   // Output register
   logic        rsp_valid_ff, rsp_kind_ff, rsp_accepted_ff, rsp_dispatched_ff;
   logic        rsp_finished_ff, rsp_idle_ff, rsp_last_ff;
   logic [2:0]  rsp_slot_ff;
   logic [5:0]  rsp_pid_ff;
   logic [15:0] rsp_arr_ff, rsp_launch_ff, rsp_planned_ff, rsp_observed_ff;

   // Memories
   proc_entry_type tbl_mem [MAX_PROCESSES];
   proc_entry_type tbl_rd_ff;
   logic [PW-1:0]  q_mem [LEVELS][MAX_PROCESSES];
   logic [PW-1:0]  q_rd_ff;
   logic [PW-1:0]  pend_mem [MAX_PROCESSES];
   logic [PW-1:0]  pend_rd_ff;

   logic           t_re, t_we;
   logic [PW-1:0]  t_raddr, t_waddr;
   proc_entry_type t_wdata;
   logic           q_re, q_we;
   logic [2:0]     q_rlvl, q_wlvl;
   logic [PW-1:0]  q_rpos, q_wpos, q_wdata;
   logic           p_re, p_we;
   logic [PW-1:0]  p_raddr, p_waddr, p_wdata;

   // Derived values
   logic           out_free, req_take, rsp_load;
   logic           free_hit, adm_ok, all_idle;
   logic [PW-1:0]  free_idx;
   logic [PW-1:0]  cur_head;
   logic [CW-1:0]  cur_cnt;
   proc_entry_type ent, upd, aged;
   logic           done, fits, due, slot_last;
   logic [3:0]     rc;
   logic [2:0]     nl, rl;
   logic [PW-1:0]  head_next;
   logic [3:0]     ncpu_sel;
   report_type     rpt_run, rpt_none, rpt_cur;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == S_ADMIT || state_ff == S_OUT);
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // First free table slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int j = MAX_PROCESSES - 1; j >= 0; j--) begin
         if (free_ff[j]) begin
            free_hit = 1'b1;
            free_idx = PW'(j);
         end
      end
   end

   always_comb begin
      all_idle = (pend_cnt_ff == '0);
      for (int j = 0; j < LEVELS; j++) begin
         if (count_ff[j] != '0) all_idle = 1'b0;
      end
   end

   assign adm_ok = free_hit && (prio_ff <= TOP_LEVEL) && (need_ff <= mem_cap_ff) &&
                   (pend_cnt_ff < MAXP_C);

   assign cur_head = head_ff[lvl_ff];
   assign cur_cnt  = count_ff[lvl_ff];
   assign head_next = wrap({1'b0, cur_head}, CW'(1));
   assign slot_last = ((slot_ff + 4'd1) == ncpu_ff);
   assign ncpu_sel  = (cpu_count_ff == 4'd0) ? 4'd1 :
                      ((cpu_count_ff > NB_W) ? NB_W : cpu_count_ff);

   // One slice of the process just read
   always_comb begin
      ent  = tbl_rd_ff;
      upd  = ent;
      aged = ent;
      if (ent.observed != 16'hFFFF) aged.observed = ent.observed + 16'd1;
      done = (ent.remaining <= 16'd1);
      if (!done) upd.remaining = ent.remaining - 16'd1;
      if (ent.launch[16]) upd.launch = {1'b0, tick_ff};
      rc = ent.run_count + 4'd1;
      if (rc >= 4'(RUNS_PER_AGING)) begin
         upd.level = aged_level(ent.level, ent.base_level);
         rc = 4'd0;
      end
      upd.run_count = rc;
      nl   = upd.level;
      rl   = (ent.level > TOP_LEVEL) ? TOP_LEVEL : ent.level;
      fits = ((mem_use_ff + {1'b0, ent.memory}) <= {1'b0, mem_cap_ff});
      due  = (ent.arrival <= tick_ff);

      rpt_run.disp     = 1'b1;
      rpt_run.fin      = done;
      rpt_run.pid      = 6'(q_rd_ff);
      rpt_run.arrival  = done ? ent.arrival : 16'd0;
      rpt_run.launch   = done ? upd.launch[15:0] : 16'd0;
      rpt_run.planned  = done ? ent.planned : 16'd0;
      rpt_run.observed = done ? ent.observed : 16'd0;
      rpt_none = '0;
      rpt_cur  = rpt_ff[slot_ff[SW-1:0]];
   end

   // Memory port control
   always_comb begin
      t_re = 1'b0; t_raddr = q_rd_ff;
      t_we = 1'b0; t_waddr = q_rd_ff; t_wdata = aged;
      q_re = 1'b0; q_rlvl = lvl_ff; q_rpos = cur_head;
      q_we = 1'b0; q_wlvl = lvl_ff; q_wpos = wrap({1'b0, cur_head}, cur_cnt);
      q_wdata = q_rd_ff;
      p_re = 1'b0; p_raddr = idx_ff[PW-1:0];
      p_we = 1'b0; p_waddr = keep_ff[PW-1:0]; p_wdata = pend_rd_ff;
      unique case (state_ff)
         S_ADMIT: begin
            t_we    = out_free && adm_ok;
            t_waddr = free_idx;
            t_wdata.arrival    = arr_ff;
            t_wdata.remaining  = slice_ff;
            t_wdata.planned    = slice_ff;
            t_wdata.launch     = UNLAUNCHED;
            t_wdata.run_count  = 4'd0;
            t_wdata.memory     = need_ff;
            t_wdata.level      = prio_ff;
            t_wdata.base_level = prio_ff;
            t_wdata.observed   = 16'd1;
            p_we    = out_free && adm_ok;
            p_waddr = pend_cnt_ff[PW-1:0];
            p_wdata = free_idx;
         end
         S_AGE_Q: begin
            q_re   = (lvl_ff != LEVELS_C) && (idx_ff < cur_cnt);
            q_rpos = wrap({1'b0, cur_head}, idx_ff);
         end
         S_AGE_T: t_re = 1'b1;
         S_AGE_W: t_we = 1'b1;
         S_REL_Q: p_re = (idx_ff < pend_cnt_ff);
         S_REL_T: begin
            t_re    = 1'b1;
            t_raddr = pend_rd_ff;
         end
         S_REL_W: begin
            q_we    = due;
            q_wlvl  = rl;
            q_wpos  = wrap({1'b0, head_ff[rl]}, count_ff[rl]);
            q_wdata = pend_rd_ff;
            p_we    = !due;
         end
         S_DSP_Q: q_re = (idx_ff < n_ff);
         S_DSP_T: t_re = !ran_ff[q_rd_ff];
         S_DSP_D: begin
            if (fits) begin
               t_we    = 1'b1;
               t_wdata = upd;
               q_we    = !done;
               q_wlvl  = nl;
               q_wpos  = wrap({1'b0, head_ff[nl]}, count_ff[nl]);
            end else begin
               q_we = 1'b1;
            end
         end
         S_IDLE, S_DSP_L, S_FIN, S_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (t_we) tbl_mem[t_waddr] <= t_wdata;
      if (t_re) tbl_rd_ff <= tbl_mem[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wlvl][q_wpos] <= q_wdata;
      if (q_re) q_rd_ff <= q_mem[q_rlvl][q_rpos];
   end

   always_ff @(posedge clock) begin
      if (p_we) pend_mem[p_waddr] <= p_wdata;
      if (p_re) pend_rd_ff <= pend_mem[p_raddr];
   end

   // Payload latches and report buffer
   always_ff @(posedge clock) begin
      if (req_take) begin
         arr_ff   <= req_arrival_time;
         slice_ff <= req_slice_count;
         need_ff  <= req_memory_need;
         prio_ff  <= req_start_priority;
      end
      if (state_ff == S_DSP_L && lvl_ff == LEVELS_C) rpt_ff[slot_ff[SW-1:0]] <= rpt_none;
      if (state_ff == S_DSP_D && fits) rpt_ff[slot_ff[SW-1:0]] <= rpt_run;
   end

   // Sequencer, control state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cpu_count_ff <= 4'd1;
         mem_cap_ff   <= 16'hFFFF;
         free_ff      <= '1;
         ran_ff       <= '0;
         for (int j = 0; j < LEVELS; j++) begin
            head_ff[j]  <= '0;
            count_ff[j] <= '0;
         end
         pend_cnt_ff  <= '0;
         tick_ff      <= '0;
         mem_use_ff   <= '0;
         lvl_ff       <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         n_ff         <= '0;
         slot_ff      <= '0;
         ncpu_ff      <= 4'd1;
         idle_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CPU_COUNT: cpu_count_ff <= csr_data[3:0];
               CSR_MEM_CAP:   mem_cap_ff   <= csr_data;
            endcase
         end

         // Output register drains unless a new result is loaded
         if (!rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  lvl_ff <= '0;
                  idx_ff <= '0;
                  if (req_func == FUNC_ADMIT) state_ff <= S_ADMIT;
                  else state_ff <= S_AGE_Q;
               end
            end
            S_ADMIT: begin
               if (out_free) begin
                  if (adm_ok) begin
                     free_ff[free_idx] <= 1'b0;
                     pend_cnt_ff       <= pend_cnt_ff + CW'(1);
                  end
                  rsp_valid_ff      <= 1'b1;
                  rsp_kind_ff       <= KIND_ADMIT;
                  rsp_accepted_ff   <= adm_ok;
                  rsp_slot_ff       <= 3'd0;
                  rsp_dispatched_ff <= 1'b0;
                  rsp_pid_ff        <= adm_ok ? 6'(free_idx) : 6'd0;
                  rsp_finished_ff   <= 1'b0;
                  rsp_arr_ff        <= 16'd0;
                  rsp_launch_ff     <= 16'd0;
                  rsp_planned_ff    <= 16'd0;
                  rsp_observed_ff   <= 16'd0;
                  rsp_idle_ff       <= adm_ok ? 1'b0 : all_idle;
                  rsp_last_ff       <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            // Age every queued process
            S_AGE_Q: begin
               if (lvl_ff == LEVELS_C) begin
                  idx_ff   <= '0;
                  keep_ff  <= '0;
                  state_ff <= S_REL_Q;
               end else if (idx_ff >= cur_cnt) begin
                  lvl_ff <= lvl_ff + 3'd1;
                  idx_ff <= '0;
               end else begin
                  state_ff <= S_AGE_T;
               end
            end
            S_AGE_T: state_ff <= S_AGE_W;
            S_AGE_W: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_AGE_Q;
            end
            // Release due pending processes
            S_REL_Q: begin
               if (idx_ff >= pend_cnt_ff) begin
                  pend_cnt_ff <= keep_ff;
                  mem_use_ff  <= '0;
                  slot_ff     <= '0;
                  ncpu_ff     <= ncpu_sel;
                  lvl_ff      <= '0;
                  state_ff    <= S_DSP_L;
               end else begin
                  state_ff <= S_REL_T;
               end
            end
            S_REL_T: state_ff <= S_REL_W;
            S_REL_W: begin
               if (due) count_ff[rl] <= count_ff[rl] + CW'(1);
               else keep_ff <= keep_ff + CW'(1);
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_REL_Q;
            end
            // Level scan for one CPU slot
            S_DSP_L: begin
               if (lvl_ff == LEVELS_C) begin
                  lvl_ff <= '0;
                  if (slot_last) state_ff <= S_FIN;
                  else slot_ff <= slot_ff + 4'd1;
               end else begin
                  n_ff     <= cur_cnt;
                  idx_ff   <= '0;
                  state_ff <= S_DSP_Q;
               end
            end
            S_DSP_Q: begin
               if (idx_ff >= n_ff) begin
                  lvl_ff   <= lvl_ff + 3'd1;
                  state_ff <= S_DSP_L;
               end else begin
                  state_ff <= S_DSP_T;
               end
            end
            S_DSP_T: begin
               if (ran_ff[q_rd_ff]) begin
                  lvl_ff   <= lvl_ff + 3'd1;
                  state_ff <= S_DSP_L;
               end else begin
                  state_ff <= S_DSP_D;
               end
            end
            S_DSP_D: begin
               head_ff[lvl_ff] <= head_next;
               if (fits) begin
                  ran_ff[q_rd_ff] <= 1'b1;
                  mem_use_ff      <= mem_use_ff + {1'b0, ent.memory};
                  if (done) begin
                     free_ff[q_rd_ff]  <= 1'b1;
                     count_ff[lvl_ff]  <= cur_cnt - CW'(1);
                  end else if (nl != lvl_ff) begin
                     count_ff[lvl_ff] <= cur_cnt - CW'(1);
                     count_ff[nl]     <= count_ff[nl] + CW'(1);
                  end
                  lvl_ff <= '0;
                  if (slot_last) state_ff <= S_FIN;
                  else begin
                     slot_ff  <= slot_ff + 4'd1;
                     state_ff <= S_DSP_L;
                  end
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_DSP_Q;
               end
            end
            S_FIN: begin
               ran_ff   <= '0;
               tick_ff  <= tick_ff + 16'd1;
               idle_ff  <= all_idle;
               slot_ff  <= '0;
               state_ff <= S_OUT;
            end
            // Deliver buffered slot reports
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_kind_ff       <= KIND_SLOT;
                  rsp_accepted_ff   <= 1'b0;
                  rsp_slot_ff       <= 3'(slot_ff);
                  rsp_dispatched_ff <= rpt_cur.disp;
                  rsp_pid_ff        <= rpt_cur.pid;
                  rsp_finished_ff   <= rpt_cur.fin;
                  rsp_arr_ff        <= rpt_cur.arrival;
                  rsp_launch_ff     <= rpt_cur.launch;
                  rsp_planned_ff    <= rpt_cur.planned;
                  rsp_observed_ff   <= rpt_cur.observed;
                  rsp_idle_ff       <= idle_ff;
                  rsp_last_ff       <= slot_last;
                  if (slot_last) state_ff <= S_IDLE;
                  else slot_ff <= slot_ff + 4'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_accepted          = rsp_accepted_ff;
   assign rsp_cpu_slot          = rsp_slot_ff;
   assign rsp_dispatched        = rsp_dispatched_ff;
   assign rsp_process_id        = rsp_pid_ff;
   assign rsp_finished          = rsp_finished_ff;
   assign rsp_arrival_out       = rsp_arr_ff;
   assign rsp_launch_time       = rsp_launch_ff;
   assign rsp_planned_duration  = rsp_planned_ff;
   assign rsp_observed_duration = rsp_observed_ff;
   assign rsp_system_idle       = rsp_idle_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

@@ design/mlq_checker.sv @@
// Port-level checks of the multilevel queue CPU scheduler, bound to the top level.
module mlq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic        rsp_accepted,
   input logic        rsp_dispatched,
   input logic [5:0]  rsp_process_id,
   input logic        rsp_finished,
   input logic        rsp_last
);
   import mlq_pkg::*;

   // An admit gives a single result
   a_admit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ADMIT |-> rsp_last)
      else $error("admit result not marked last");

   // A rejected admit names no process
   a_reject_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ADMIT && !rsp_accepted |-> rsp_process_id == 6'd0)
      else $error("rejected admit carries a process id");

   // Only a dispatched process can finish
   a_fin_disp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_dispatched && rsp_kind == KIND_SLOT)
      else $error("finish without dispatch");

   // One request at a time: stall rises after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_process_id) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind multilevel_queue_cpu_scheduler_core mlq_checker u_mlq_checker (.*);

@@ dv/multilevel_queue_cpu_scheduler_core_test.sv @@
// Self-checking testbench of the multilevel queue CPU scheduler core.
module multilevel_queue_cpu_scheduler_core_test;
   import mlq_pkg::*;

   localparam int NPROC = 64;
   localparam int NLVL = 5;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int REQ_DEPTH = 1024;
   localparam int EXP_DEPTH = 4096;

   typedef struct {
      logic        func;
      logic [15:0] arrival;
      logic [15:0] slices;
      logic [15:0] memory;
      logic [2:0]  prio;
   } sched_request_type;

   typedef struct {
      logic        kind;
      logic        accepted;
      logic [2:0]  cpu_slot;
      logic        dispatched;
      logic [5:0]  pid;
      logic        finished;
      logic [15:0] arrival;
      logic [15:0] launch;
      logic [15:0] planned;
      logic [15:0] observed;
      logic        idle;
      logic        last;
   } slot_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_slice_count = '0;
   logic [15:0] req_memory_need = '0;
   logic [2:0]  req_start_priority = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic        rsp_accepted;
   logic [2:0]  rsp_cpu_slot;
   logic        rsp_dispatched;
   logic [5:0]  rsp_process_id;
   logic        rsp_finished;
   logic [15:0] rsp_arrival_out;
   logic [15:0] rsp_launch_time;
   logic [15:0] rsp_planned_duration;
   logic [15:0] rsp_observed_duration;
   logic        rsp_system_idle;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_CPU_COUNT;
   logic [15:0] csr_data = '0;

   multilevel_queue_cpu_scheduler_core u_dut (.*);

   always #5 clock = ~clock;

   // scheduler mirror
   logic [15:0] pr_arrival [NPROC];
   logic [15:0] pr_remaining [NPROC];
   logic [15:0] pr_planned [NPROC];
   logic [16:0] pr_launch [NPROC];
   int          pr_runs [NPROC];
   logic [15:0] pr_memory [NPROC];
   int          pr_level [NPROC];
   int          pr_base [NPROC];
   logic [15:0] pr_observed [NPROC];
   bit          pr_ran [NPROC];
   bit          slot_free [NPROC];
   int          run_queue [NLVL][NPROC];
   int          queue_head [NLVL];
   int          queue_len [NLVL];
   int          waiting_list [NPROC];
   int          waiting_len;
   logic [15:0] tick_now;
   int          cpu_setting;
   int          mem_capacity;

   // pending requests and expected results, kept as rings
   sched_request_type req_buf [REQ_DEPTH];
   int                req_wr = 0;
   int                req_rd = 0;
   slot_report_type   exp_buf [EXP_DEPTH];
   int                exp_wr = 0;
   int                exp_rd = 0;
   int                error_count = 0;
   int                send_idle_pct = 20;
   int                recv_stall_pct = 87;
   int                gen_tick = 0;
   int                gen_capacity = 65535;
   bit                took_request = 1'b0;
   int                quiet_cycles = 0;

   function automatic void store_request(sched_request_type rq);
      req_buf[req_wr % REQ_DEPTH] = rq;
      req_wr++;
   endfunction

   function automatic sched_request_type fetch_request();
      sched_request_type rq;
      rq = req_buf[req_rd % REQ_DEPTH];
      req_rd++;
      return rq;
   endfunction

   function automatic void store_report(slot_report_type r);
      exp_buf[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endfunction

   function automatic slot_report_type fetch_report();
      slot_report_type r;
      r = exp_buf[exp_rd % EXP_DEPTH];
      exp_rd++;
      return r;
   endfunction

   function automatic void queue_append(int lv, int p);
      if (lv >= NLVL || queue_len[lv] >= NPROC) return;
      run_queue[lv][(queue_head[lv] + queue_len[lv]) % NPROC] = p;
      queue_len[lv]++;
   endfunction

   function automatic int queue_take(int lv);
      int p;
      p = run_queue[lv][queue_head[lv] % NPROC];
      queue_head[lv] = (queue_head[lv] + 1) % NPROC;
      queue_len[lv]--;
      return p;
   endfunction

   function automatic bit nothing_left();
      if (waiting_len != 0) return 1'b0;
      for (int l = 0; l < NLVL; l++)
         if (queue_len[l] != 0) return 1'b0;
      return 1'b1;
   endfunction

   // one slice of process p; returns 1 when it finished
   function automatic bit run_one_slice(int p);
      bit done;
      done = pr_remaining[p] <= 1;
      if (!done) pr_remaining[p]--;
      if (pr_launch[p][16]) pr_launch[p] = {1'b0, tick_now};
      pr_runs[p]++;
      if (pr_runs[p] >= RUNS_PER_AGING) begin
         if (pr_base[p] != 0 && pr_base[p] != 4) begin
            if (pr_level[p] != 4 || pr_base[p] == pr_level[p]) pr_level[p]++;
            else pr_level[p]--;
            if (pr_level[p] > 4) pr_level[p] = 4;
         end
         pr_runs[p] = 0;
      end
      pr_ran[p] = 1'b1;
      return done;
   endfunction

   function automatic void reset_schedule();
      for (int i = 0; i < NPROC; i++) begin
         slot_free[i] = 1'b1;
         pr_ran[i] = 1'b0;
      end
      for (int l = 0; l < NLVL; l++) begin
         queue_head[l] = 0;
         queue_len[l] = 0;
      end
      waiting_len = 0;
      tick_now = '0;
      cpu_setting = 1;
      mem_capacity = 65535;
   endfunction

   // work out the reports that one request causes
   function automatic void schedule_request(sched_request_type rq);
      slot_report_type r;
      slot_report_type tick_reports [REPORT_LIMIT];
      int p, keep, ncpu, mem_used, pid;
      bit disp, fin;
      r = '{default: '0};
      if (rq.func == FUNC_ADMIT) begin
         p = -1;
         for (int i = 0; i < NPROC; i++)
            if (slot_free[i]) begin
               p = i;
               break;
            end
         r.kind = KIND_ADMIT;
         r.last = 1'b1;
         if (p < 0 || rq.prio > 4 || rq.memory > mem_capacity || waiting_len >= NPROC) begin
            r.idle = nothing_left();
         end else begin
            slot_free[p] = 1'b0;
            pr_arrival[p] = rq.arrival;
            pr_remaining[p] = rq.slices;
            pr_planned[p] = rq.slices;
            pr_launch[p] = UNLAUNCHED;
            pr_runs[p] = 0;
            pr_memory[p] = rq.memory;
            pr_level[p] = int'(rq.prio);
            pr_base[p] = int'(rq.prio);
            pr_observed[p] = 16'd1;
            pr_ran[p] = 1'b0;
            waiting_list[waiting_len++] = p;
            r.accepted = 1'b1;
            r.pid = 6'(p);
         end
         store_report(r);
         return;
      end
      // age queued processes
      for (int l = 0; l < NLVL; l++)
         for (int i = 0; i < queue_len[l]; i++) begin
            p = run_queue[l][(queue_head[l] + i) % NPROC];
            if (pr_observed[p] != 16'hFFFF) pr_observed[p]++;
         end
      // release due arrivals, keeping the order of the rest
      keep = 0;
      for (int i = 0; i < waiting_len; i++) begin
         p = waiting_list[i];
         if (pr_arrival[p] <= tick_now) queue_append(pr_level[p] > 4 ? 4 : pr_level[p], p);
         else waiting_list[keep++] = p;
      end
      waiting_len = keep;
      ncpu = cpu_setting;
      if (ncpu == 0) ncpu = 1;
      if (ncpu > REPORT_LIMIT) ncpu = REPORT_LIMIT;
      mem_used = 0;
      // fill each CPU slot from the first level with a fitting process
      for (int s = 0; s < ncpu; s++) begin
         disp = 1'b0;
         fin = 1'b0;
         pid = 0;
         for (int l = 0; l < NLVL && !disp; l++) begin
            int n;
            n = queue_len[l];
            for (int i = 0; i < n; i++) begin
               p = run_queue[l][queue_head[l] % NPROC];
               if (pr_ran[p]) break;
               if (mem_used + pr_memory[p] <= mem_capacity) begin
                  disp = 1'b1;
                  break;
               end
               queue_append(l, queue_take(l));
            end
            if (disp) begin
               pid = queue_take(l);
               mem_used += pr_memory[pid];
               fin = run_one_slice(pid);
               if (fin) slot_free[pid] = 1'b1;
               else queue_append(pr_level[pid], pid);
            end
         end
         r = '{default: '0};
         r.kind = KIND_SLOT;
         r.cpu_slot = 3'(s);
         r.dispatched = disp;
         r.pid = disp ? 6'(pid) : 6'd0;
         if (fin) begin
            r.finished = 1'b1;
            r.arrival = pr_arrival[pid];
            r.launch = pr_launch[pid][15:0];
            r.planned = pr_planned[pid];
            r.observed = pr_observed[pid];
         end
         tick_reports[s] = r;
      end
      for (int i = 0; i < NPROC; i++) pr_ran[i] = 1'b0;
      tick_now++;
      for (int s = 0; s < ncpu; s++) begin
         tick_reports[s].idle = nothing_left();
         tick_reports[s].last = (s == ncpu - 1);
         store_report(tick_reports[s]);
      end
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // monitor: predict on request transfers, check on result transfers
   always @(posedge clock) begin
      slot_report_type w;
      if (!reset) begin
         took_request <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CPU_COUNT) cpu_setting = int'(csr_data[3:0]);
            else mem_capacity = int'(csr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               w = fetch_report();
               if (rsp_kind !== w.kind) report_mismatch("kind", rsp_kind, w.kind);
               if (rsp_accepted !== w.accepted)
                  report_mismatch("accepted", rsp_accepted, w.accepted);
               if (rsp_cpu_slot !== w.cpu_slot)
                  report_mismatch("cpu_slot", rsp_cpu_slot, w.cpu_slot);
               if (rsp_dispatched !== w.dispatched)
                  report_mismatch("dispatched", rsp_dispatched, w.dispatched);
               if (rsp_process_id !== w.pid)
                  report_mismatch("process_id", rsp_process_id, w.pid);
               if (rsp_finished !== w.finished)
                  report_mismatch("finished", rsp_finished, w.finished);
               if (rsp_arrival_out !== w.arrival)
                  report_mismatch("arrival_out", rsp_arrival_out, w.arrival);
               if (rsp_launch_time !== w.launch)
                  report_mismatch("launch_time", rsp_launch_time, w.launch);
               if (rsp_planned_duration !== w.planned)
                  report_mismatch("planned_duration", rsp_planned_duration, w.planned);
               if (rsp_observed_duration !== w.observed)
                  report_mismatch("observed_duration", rsp_observed_duration, w.observed);
               if (rsp_system_idle !== w.idle)
                  report_mismatch("system_idle", rsp_system_idle, w.idle);
               if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
            end
         end
         if (req_valid && !req_stall)
            schedule_request('{req_func, req_arrival_time, req_slice_count,
                               req_memory_need, req_start_priority});
         // watchdog on cycles without any transfer
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("multilevel_queue_cpu_scheduler_core: mismatch");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // request driver
   always @(negedge clock) begin
      sched_request_type rq;
      if (!reset && (!req_valid || took_request)) begin
         if (req_wr != req_rd && $urandom_range(99) >= send_idle_pct) begin
            rq = fetch_request();
            req_valid <= 1'b1;
            req_func <= rq.func;
            req_arrival_time <= rq.arrival;
            req_slice_count <= rq.slices;
            req_memory_need <= rq.memory;
            req_start_priority <= rq.prio;
         end else
            req_valid <= 1'b0;
      end
   end

   // result stall
   always @(negedge clock)
      if (!reset) rsp_stall <= $urandom_range(99) < recv_stall_pct;

   task automatic add_admit(int arrival, int slices, int memory, int prio);
      store_request('{FUNC_ADMIT, arrival[15:0], slices[15:0],
                      memory[15:0], prio[2:0]});
   endtask

   task automatic add_tick();
      store_request('{FUNC_TICK, 16'($urandom), 16'($urandom),
                      16'($urandom), 3'($urandom)});
      gen_tick++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_wr != req_rd || req_valid || exp_wr != exp_rd);
   endtask

   task automatic write_csr(logic idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MEM_CAP) gen_capacity = value & 16'hFFFF;
   endtask

   // random traffic: mostly admit bursts followed by ticks, some noise
   task automatic random_traffic(int n);
      int k;
      k = 0;
      while (k < n) begin
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) add_tick();
            else add_admit($urandom, $urandom, $urandom, $urandom_range(7));
            k++;
         end else begin
            repeat ($urandom_range(0, 4)) begin
               add_admit(gen_tick + $urandom_range(0, 4), $urandom_range(0, 25),
                         $urandom_range(0, gen_capacity), $urandom_range(0, 4));
               k++;
            end
            repeat ($urandom_range(1, 4)) begin
               add_tick();
               k++;
            end
         end
      end
   endtask

   initial begin
      reset_schedule();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: priority and memory limits, zero slices, extreme fields
      write_csr(CSR_CPU_COUNT, 3);
      write_csr(CSR_MEM_CAP, 1000);
      for (int p = 0; p < 8; p++) add_admit(0, p + 1, 100 * p, p);
      add_admit(0, 2, 1001, 1);
      add_admit(0, 0, 1000, 2);
      add_admit(1, 65535, 0, 3);
      add_admit(65535, 4, 0, 0);
      repeat (8) add_tick();
      wait_drained();

      // sender idles less than the receiver stalls
      write_csr(CSR_CPU_COUNT, $urandom_range(1, 8));
      write_csr(CSR_MEM_CAP, $urandom_range(500, 65535));
      random_traffic(80);
      wait_drained();

      // the other way round
      send_idle_pct = 87;
      recv_stall_pct = 20;
      write_csr(CSR_CPU_COUNT, 0);
      write_csr(CSR_MEM_CAP, 0);
      random_traffic(40);
      wait_drained();
      write_csr(CSR_CPU_COUNT, 15);
      write_csr(CSR_MEM_CAP, 65535);
      random_traffic(40);
      wait_drained();

      // no idling: fill the table past its size, then drain it
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_CPU_COUNT, 8);
      write_csr(CSR_MEM_CAP, 300);
      for (int i = 0; i < 66; i++) add_admit(gen_tick + 1, 1, $urandom_range(0, 300), 4);
      repeat (12) add_tick();
      random_traffic(20);
      wait_drained();

      repeat (50) @(posedge clock);
      if (error_count == 0) $display("multilevel_queue_cpu_scheduler_core: match");
      else $display("multilevel_queue_cpu_scheduler_core: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
design/mlq_pkg.sv
design/multilevel_queue_cpu_scheduler_core.sv
design/mlq_checker.sv
dv/multilevel_queue_cpu_scheduler_core_test.sv
